// ----- src/bhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types, constants and helpers for the binary heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bhpq_pkg;

  localparam int unsigned CAPACITY  = 64;
  localparam int unsigned KEY_WIDTH = 32;
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned ADDR_W    = $clog2(CAPACITY);
  localparam int unsigned SLOT_W    = 7;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;
  localparam logic [1:0] OP_UPDATE = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BADSLOT = 2'd3;

  typedef logic [KEY_WIDTH-1:0] key_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [31:0]       key_in;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic [31:0] key_out;
    logic [6:0]  entry_count;
    logic [1:0]  status;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    key_t              wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } ram_req_t;

  // a strictly ahead of b in service order
  function automatic logic outranks(input logic max_first, input key_t a, input key_t b);
    outranks = max_first ? (a > b) : (a < b);
  endfunction

endpackage

`default_nettype wire

// ----- src/bhpq_ram.sv -----
// ----------------------------------------------------------------------------
// bhpq_ram
// Generic RAM, one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 64,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// ----- src/bhpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bhpq_ctrl
// Operation sequencer: decodes a command, walks the heap one level per
// read/compare pair, moving a hole and writing the carried key at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               max_first_i,
  input  wire logic               start_i,
  input  wire bhpq_pkg::cmd_t     cmd_i,
  output logic                    busy_o,
  output logic                    res_valid_o,
  output bhpq_pkg::res_t          res_o,
  output bhpq_pkg::ram_req_t      ram_req_o,
  input  wire bhpq_pkg::key_t     rdata_a_i,
  input  wire bhpq_pkg::key_t     rdata_b_i
);

  import bhpq_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_POP    = 4'd1;
  localparam logic [3:0] S_PEEK   = 4'd2;
  localparam logic [3:0] S_UPD    = 4'd3;
  localparam logic [3:0] S_UP_RD  = 4'd4;
  localparam logic [3:0] S_UP_CMP = 4'd5;
  localparam logic [3:0] S_DN_RD  = 4'd6;
  localparam logic [3:0] S_DN_CMP = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CAPACITY);

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  key_t             mov_q, mov_d;
  key_t             rkey_q, rkey_d;
  logic [1:0]       status_q, status_d;

  logic [CNT_W:0]   lc, rc, cnt_x;
  logic             rc_ok, pick_r;
  key_t             pick_val;
  key_t             key_m;
  logic [CNT_W-1:0] slot_c;

  assign key_m  = KEY_WIDTH'(cmd_i.key_in);
  assign slot_c = CNT_W'(cmd_i.slot);
  assign lc     = {pos_q, 1'b0};
  assign rc     = lc + (CNT_W+1)'(1);
  assign cnt_x  = {1'b0, count_q};
  assign rc_ok  = rc <= cnt_x;
  assign pick_r = rc_ok && !outranks(max_first_i, rdata_a_i, rdata_b_i);
  assign pick_val = pick_r ? rdata_b_i : rdata_a_i;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    pos_d    = pos_q;
    mov_d    = mov_q;
    rkey_d   = rkey_q;
    status_d = status_q;
    ram_req_o.we      = 1'b0;
    ram_req_o.waddr   = ADDR_W'(pos_q - CNT_ONE);
    ram_req_o.wdata   = mov_q;
    ram_req_o.raddr_a = '0;
    ram_req_o.raddr_b = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          rkey_d   = '0;
          status_d = ST_OK;
          case (cmd_i.opcode)
            OP_PUSH: begin
              if (count_q == CNT_MAX) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else begin
                count_d = count_q + CNT_ONE;
                pos_d   = count_q + CNT_ONE;
                mov_d   = key_m;
                state_d = S_UP_RD;
              end
            end
            OP_POP: begin
              ram_req_o.raddr_a = '0;
              ram_req_o.raddr_b = ADDR_W'(count_q - CNT_ONE);
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end else begin
                state_d = S_POP;
              end
            end
            OP_PEEK: begin
              ram_req_o.raddr_a = '0;
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end else begin
                state_d = S_PEEK;
              end
            end
            default: begin
              ram_req_o.raddr_a = ADDR_W'(slot_c - CNT_ONE);
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end else if (cmd_i.slot == '0 || cmd_i.slot > SLOT_W'(count_q)) begin
                status_d = ST_BADSLOT;
                state_d  = S_DONE;
              end else begin
                mov_d   = key_m;
                pos_d   = slot_c;
                state_d = S_UPD;
              end
            end
          endcase
        end
      end
      S_POP: begin
        rkey_d  = rdata_a_i;
        mov_d   = rdata_b_i;
        count_d = count_q - CNT_ONE;
        pos_d   = CNT_ONE;
        state_d = S_DN_RD;
      end
      S_PEEK: begin
        rkey_d  = rdata_a_i;
        state_d = S_DONE;
      end
      S_UPD: begin
        state_d = outranks(max_first_i, mov_q, rdata_a_i) ? S_UP_RD : S_DN_RD;
      end
      S_UP_RD: begin
        ram_req_o.raddr_a = ADDR_W'((pos_q >> 1) - CNT_ONE);
        if (pos_q == CNT_ONE) begin
          ram_req_o.we = 1'b1;
          state_d      = S_DONE;
        end else begin
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ram_req_o.we = 1'b1;
        if (outranks(max_first_i, mov_q, rdata_a_i)) begin
          ram_req_o.wdata = rdata_a_i;
          pos_d           = pos_q >> 1;
          state_d         = S_UP_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DN_RD: begin
        ram_req_o.raddr_a = ADDR_W'(lc - (CNT_W+1)'(1));
        ram_req_o.raddr_b = ADDR_W'(lc);
        if (lc > cnt_x) begin
          ram_req_o.we = 1'b1;
          state_d      = S_DONE;
        end else begin
          state_d = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        ram_req_o.we = 1'b1;
        if (outranks(max_first_i, mov_q, pick_val)) begin
          state_d = S_DONE;
        end else begin
          ram_req_o.wdata = pick_val;
          pos_d           = pick_r ? CNT_W'(rc) : CNT_W'(lc);
          state_d         = S_DN_RD;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    mov_q    <= mov_d;
    rkey_q   <= rkey_d;
    status_q <= status_d;
  end

  assign busy_o            = state_q != S_IDLE;
  assign res_valid_o       = state_q == S_DONE;
  assign res_o.key_out     = 32'(rkey_q);
  assign res_o.entry_count = 7'(count_q);
  assign res_o.status      = status_q;

endmodule

`default_nettype wire

// ----- src/binary_heap_priority_queue.sv -----
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Min- or max-first binary heap of keys held in one dual-read RAM.
//
//   channel   handshake             word
//   command   start_i / busy_o      cmd_i   (opcode, key_in, slot)
//   result    res_valid_o strobe    res_o   (key_out, entry_count, status)
//   config    APB psel/penable      pwdata  (max_first at address 0)
//
// An error result goes straight to the result state; a peek first reads the root.
// A sift walks one heap level per RAM read, then compare and write back,
// and ends with a closing write; pop and update begin with a first read.
// busy_o is high from acceptance until the result strobe cycle ends.
// Reset clears the count and ordering; RAM contents are never cleared.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_heap_priority_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire bhpq_pkg::cmd_t  cmd_i,
  output logic                 busy_o,
  output logic                 res_valid_o,
  output bhpq_pkg::res_t       res_o,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [2:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic      [31:0]     prdata,
  output logic                 pready
);

  import bhpq_pkg::*;

  logic     max_first_q;
  ram_req_t ram_req;
  key_t     rdata_a, rdata_b;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'b0, max_first_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_first_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      max_first_q <= pwdata[0];
    end
  end

  bhpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_first_i (max_first_q),
    .start_i     (start_i),
    .cmd_i       (cmd_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .ram_req_o   (ram_req),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b)
  );

  bhpq_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_req.we),
    .waddr_i   (ram_req.waddr),
    .wdata_i   (ram_req.wdata),
    .raddr_a_i (ram_req.raddr_a),
    .raddr_b_i (ram_req.raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary heap priority queue. A driver feeds
// command words from a queue filled by the stimulus process; a monitor keeps
// a shadow heap, predicts each result word at acceptance and compares every
// strobed result against it. Stimulus runs directed corner cases, then fill
// and drain waves in both orderings, with the ordering flipped while keys
// are held and with sender gaps in some phases.
// ----------------------------------------------------------------------------

module tb_top;
  import bhpq_pkg::*;

  localparam logic [2:0] REG_MAX_FIRST = 3'd0;
  localparam int unsigned RAND_PER_PHASE = 338;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start_i = 1'b0;
  cmd_t        cmd_i   = '0;
  logic        busy_o;
  logic        res_valid_o;
  res_t        res_o;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  always #5 clk_i = ~clk_i;

  binary_heap_priority_queue dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .cmd_i      (cmd_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // shadow heap
  key_t        heap_mdl [1:CAPACITY];
  int unsigned heap_len  = 0;
  logic        order_max = 1'b0;

  function automatic logic ranks_ahead(key_t a, key_t b);
    return order_max ? (a > b) : (a < b);
  endfunction

  function automatic void swap_keys(int unsigned i, int unsigned j);
    key_t t;
    t           = heap_mdl[i];
    heap_mdl[i] = heap_mdl[j];
    heap_mdl[j] = t;
  endfunction

  function automatic void rise_from(int unsigned pos);
    int unsigned up;
    while (pos > 1) begin
      up = pos / 2;
      if (!ranks_ahead(heap_mdl[pos], heap_mdl[up])) break;
      swap_keys(pos, up);
      pos = up;
    end
  endfunction

  function automatic void sink_from(int unsigned pos);
    int unsigned pick;
    while (2 * pos <= heap_len) begin
      pick = 2 * pos;
      // right child wins ties
      if (pick + 1 <= heap_len && !ranks_ahead(heap_mdl[pick], heap_mdl[pick + 1]))
        pick = pick + 1;
      if (ranks_ahead(heap_mdl[pos], heap_mdl[pick])) break;
      swap_keys(pos, pick);
      pos = pick;
    end
  endfunction

  function automatic res_t heap_apply(cmd_t c);
    res_t r;
    key_t prev;
    r = '0;
    r.status = ST_OK;
    case (c.opcode)
      OP_PUSH: begin
        if (heap_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          heap_len++;
          heap_mdl[heap_len] = c.key_in;
          rise_from(heap_len);
        end
      end
      OP_POP: begin
        if (heap_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.key_out   = heap_mdl[1];
          heap_mdl[1] = heap_mdl[heap_len];
          heap_len--;
          sink_from(1);
        end
      end
      OP_PEEK: begin
        if (heap_len == 0) r.status = ST_EMPTY;
        else r.key_out = heap_mdl[1];
      end
      default: begin
        if (heap_len == 0) begin
          r.status = ST_EMPTY;
        end else if (c.slot == 0 || c.slot > heap_len) begin
          r.status = ST_BADSLOT;
        end else begin
          prev = heap_mdl[c.slot];
          heap_mdl[c.slot] = c.key_in;
          if (ranks_ahead(c.key_in, prev)) rise_from(c.slot);
          else sink_from(c.slot);
        end
      end
    endcase
    r.entry_count = 7'(heap_len);
    return r;
  endfunction

  cmd_t        cmd_q[$];
  res_t        expected_res_q[$];
  int unsigned words_out    = 0;
  int unsigned words_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned errors       = 0;
  int unsigned full_seen    = 0;
  int unsigned empty_seen   = 0;
  int unsigned bad_seen     = 0;
  int unsigned peak_len     = 0;
  bit          accept_seen  = 1'b0;
  int unsigned gap_pct      = 0;
  int unsigned idle_left    = 0;

  // monitor: predict on acceptance, check on strobe
  always @(posedge clk_i) begin
    res_t want;
    accept_seen = rst_ni && start_i && !busy_o;
    if (accept_seen) begin
      words_taken++;
      expected_res_q.insert(expected_res_q.size(), heap_apply(cmd_i));
      if (heap_len > peak_len) peak_len = heap_len;
    end
    if (rst_ni && res_valid_o) begin
      if (expected_res_q.size() == 0) begin
        errors++;
        $error("result word with none expected: key_out %h entry_count %0d status %0d",
               res_o.key_out, res_o.entry_count, res_o.status);
      end else begin
        want = expected_res_q.pop_front();
        results_seen++;
        if (res_o.key_out !== want.key_out) begin
          errors++;
          $error("key_out: expected %h, actual %h", want.key_out, res_o.key_out);
        end
        if (res_o.entry_count !== want.entry_count) begin
          errors++;
          $error("entry_count: expected %0d, actual %0d", want.entry_count, res_o.entry_count);
        end
        if (res_o.status !== want.status) begin
          errors++;
          $error("status: expected %0d, actual %0d", want.status, res_o.status);
        end
        case (want.status)
          ST_FULL:    full_seen++;
          ST_EMPTY:   empty_seen++;
          ST_BADSLOT: bad_seen++;
          default:    ;
        endcase
      end
    end
  end

  // driver: start stays high across back-to-back words
  always @(negedge clk_i) begin
    if (rst_ni && (!start_i || accept_seen)) begin
      if (idle_left > 0) begin
        idle_left--;
        start_i <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        cmd_i   <= cmd_q.pop_front();
        start_i <= 1'b1;
        words_out++;
        if (gap_pct > 0 && (words_out / 32) % 3 != 2 && $urandom_range(0, 99) < gap_pct)
          idle_left = $urandom_range(1, 20);
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // stimulus generation
  int unsigned gen_len   = 0;
  int unsigned gen_wave  = 0;
  int unsigned overshoot = 0;
  int unsigned mixed_left = 0;

  localparam int unsigned WAVE_FILL  = 0;
  localparam int unsigned WAVE_DRAIN = 1;
  localparam int unsigned WAVE_MIXED = 2;

  task automatic add_cmd(logic [1:0] op, key_t key, logic [6:0] slot);
    cmd_t c;
    c.opcode = op;
    c.key_in = key;
    c.slot   = slot;
    cmd_q.insert(cmd_q.size(), c);
    if (op == OP_PUSH && gen_len < CAPACITY) gen_len++;
    if (op == OP_POP && gen_len > 0) gen_len--;
  endtask

  function automatic key_t rand_key();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $urandom;
    if (pick < 7) return $urandom_range(0, 15);
    if (pick < 8) return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    return 32'hFFFF_FFF0 | $urandom_range(0, 15);
  endfunction

  task automatic queue_random(int unsigned n);
    int unsigned roll;
    logic [1:0]  op;
    logic [6:0]  slot;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      case (gen_wave)
        WAVE_FILL: begin
          if (roll < 70) op = OP_PUSH;
          else if (roll < 82) op = OP_POP;
          else if (roll < 88) op = OP_PEEK;
          else op = OP_UPDATE;
          if (gen_len == CAPACITY) overshoot++;
          if (overshoot > 3) begin
            gen_wave  = WAVE_DRAIN;
            overshoot = 0;
          end
        end
        WAVE_DRAIN: begin
          if (roll < 65) op = OP_POP;
          else if (roll < 77) op = OP_PUSH;
          else if (roll < 85) op = OP_PEEK;
          else op = OP_UPDATE;
          if (gen_len == 0) overshoot++;
          if (overshoot > 3) begin
            overshoot = 0;
            if ($urandom_range(0, 1)) begin
              gen_wave = WAVE_FILL;
            end else begin
              gen_wave   = WAVE_MIXED;
              mixed_left = 60;
            end
          end
        end
        default: begin
          op = 2'($urandom_range(0, 3));
          if (mixed_left > 0) mixed_left--;
          else gen_wave = WAVE_FILL;
        end
      endcase
      if (op == OP_UPDATE && gen_len > 0 && $urandom_range(0, 9) < 8)
        slot = 7'($urandom_range(1, gen_len));
      else
        slot = 7'($urandom_range(0, 127));
      add_cmd(op, rand_key(), slot);
    end
  endtask

  task automatic settle();
    while (!(cmd_q.size() == 0 && words_out == words_taken && expected_res_q.size() == 0))
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_order(logic v);
    logic [31:0] rd;
    @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b1;
    paddr   = REG_MAX_FIRST;
    pwdata  = {31'b0, v};
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    order_max = v;
    @(negedge clk_i);
    psel = 1'b1;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (rd[0] !== v) begin
      errors++;
      $error("max_first: expected %0d, actual %0d", v, rd[0]);
    end
  endtask

  initial begin
    int unsigned wait_cycles;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // empty-queue errors, equal keys, key extremes, bad slots, both sift directions
    add_cmd(OP_POP, $urandom, 7'd1);
    add_cmd(OP_PEEK, $urandom, 7'd127);
    add_cmd(OP_UPDATE, 32'h0000_1234, 7'd1);
    add_cmd(OP_PUSH, 32'hFFFF_FFFF, 7'd0);
    add_cmd(OP_PUSH, 32'h0, 7'd127);
    add_cmd(OP_PUSH, 32'd5, 7'd1);
    add_cmd(OP_PUSH, 32'd5, 7'd2);
    add_cmd(OP_PUSH, 32'h8000_0000, 7'd64);
    add_cmd(OP_PUSH, 32'd1, 7'd3);
    add_cmd(OP_PEEK, $urandom, 7'd0);
    add_cmd(OP_UPDATE, 32'd9, 7'd0);
    add_cmd(OP_UPDATE, 32'd9, 7'd7);
    add_cmd(OP_UPDATE, 32'd9, 7'd127);
    add_cmd(OP_UPDATE, 32'h0, 7'd6);
    add_cmd(OP_UPDATE, 32'hFFFF_FFFF, 7'd1);
    add_cmd(OP_UPDATE, 32'd5, 7'd2);
    add_cmd(OP_POP, $urandom, 7'd0);
    add_cmd(OP_POP, $urandom, 7'd64);
    add_cmd(OP_POP, $urandom, 7'd5);
    settle();

    // flip ordering with keys still held
    set_order(1'b1);
    add_cmd(OP_PEEK, $urandom, 7'd1);
    add_cmd(OP_POP, $urandom, 7'd1);
    add_cmd(OP_PUSH, 32'd7, 7'd1);
    add_cmd(OP_UPDATE, 32'hFFFF_FFFF, 7'd2);
    add_cmd(OP_POP, $urandom, 7'd1);
    settle();

    for (int k = 0; k < 4; k++) begin
      set_order(k % 2 == 1);
      gap_pct = (k == 1) ? 56 : (k == 3) ? 35 : 0;
      queue_random(RAND_PER_PHASE);
      settle();
    end
    set_order(1'b0);

    wait_cycles = 0;
    while (expected_res_q.size() != 0 && wait_cycles < 2000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (40) @(posedge clk_i);
    if (expected_res_q.size() != 0) begin
      errors += expected_res_q.size();
      $error("%0d result words never arrived", expected_res_q.size());
    end

    $display("%0d result words checked over %0d commands in min- and max-first order,",
             results_seen, words_taken);
    $display("peak fill %0d of %0d, full drops %0d, empty %0d, bad slot %0d, mismatches %0d",
             peak_len, CAPACITY, full_seen, empty_seen, bad_seen, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
